@@ hdl/sspc_pkg.sv @@
// Shared types and constants for the state-space pendulum controller.
// No dependencies.
package sspc_pkg;

  localparam int CFG_WIDTH = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DRIVE_BITS = 17;
  localparam int DAC_BITS = 12;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CAL    = 3'd0,
    REG_A0     = 3'd1,
    REG_A1     = 3'd2,
    REG_A2     = 3'd3,
    REG_A3     = 3'd4,
    REG_BUPPER = 3'd5,
    REG_BLOWER = 3'd6,
    REG_GAINS  = 3'd7
  } reg_index_t;

  localparam logic [55:0] CAL_RESET = 56'd396930057832459;
  localparam int POS_OFFSET = 629146;
  localparam int DRIVE_LIMIT = 40960;

  // Control between sequencer and serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

endpackage

@@ hdl/sspc_if.sv @@
// Valid/ready channel interface used for input and result transfers.
// Depends on nothing; payload width is a parameter.
interface sspc_if #(parameter int W = 24) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hdl/sspc_mac.sv @@
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on sspc_pkg for the control struct.
module sspc_mac #(
  parameter int AW = 40,
  parameter int BW = 20,
  parameter int ACCW = 72
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sspc_pkg::mac_ctrl_t    ctrl,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic                   busy,
  output logic signed [ACCW-1:0] acc
);
  localparam int CNTW = $clog2(BW + 1);

  logic signed [ACCW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CNTW-1:0] cnt;

  // Shift-add; the top multiplier bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      acc <= '0;
    end else begin
      if (ctrl.clear) acc <= '0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt <= CNTW'(BW);
        mcand <= ACCW'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == CNTW'(1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("busy with empty count");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0) else $error("idle with live count");
  a_nostart: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(ctrl.start)) else $error("busy without start");
`endif
endmodule

@@ hdl/state_space_pendulum_controller_top.sv @@
// Top level of the state-space observer controller for a cart and pendulum.
// Depends on sspc_pkg, sspc_if and sspc_mac.
//
//  channel | direction | payload
//  samples | in        | angle_code, position_code
//  drive   | out       | dac_code, drive_value, drive_clamped
//  cfg     | in        | cfg_we, cfg_index, cfg_data
//
// One item takes 30 serial products (two measurements, six per state row, four for
// the drive), each run in turn on the shared bit-serial multiply-accumulate unit.
// Reset clears the observer state and loads default calibration.
// A finished result waits in the output register; the next item is taken meanwhile and
// only its own result stalls while the previous one still waits.
module state_space_pendulum_controller_top #(
  parameter int SAMPLE_BITS = 12,
  parameter int COEF_BITS = 16,
  parameter int STATE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [sspc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sspc_pkg::CFG_WIDTH-1:0] cfg_data,
  sspc_if.sink samples,
  sspc_if.source drive
);
  localparam int AW = STATE_BITS + 2;
  localparam int BW = 20;
  localparam int ACCW = AW + BW + 4;
  localparam logic signed [STATE_BITS-1:0] SMAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] SMIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic [11:0] SMASK = 12'((64'd1 << SAMPLE_BITS) - 64'd1);
  // floor(n / 5) equals (n * 26215) >> 17 for every n below 43690.
  localparam logic [29:0] DIV5_RECIP = 30'd26215;

  typedef enum logic [2:0] {S_IDLE, S_SCALE, S_ROW, S_WAIT, S_ROWEND, S_DRV, S_OUT} state_t;

  logic [55:0] cal;
  logic [63:0] regs [1:7];
  logic signed [STATE_BITS-1:0] xs [4];
  logic signed [STATE_BITS-1:0] xn [4];
  logic signed [STATE_BITS-1:0] y0, y1;
  state_t state;
  logic [2:0] term;
  logic [2:0] row;
  logic ydone;
  logic drv;
  sspc_pkg::mac_ctrl_t ctrl;
  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic mbusy;
  logic signed [ACCW-1:0] acc;
  logic [11:0] ang, pos;
  logic [11:0] dac_r;
  logic signed [16:0] drv_r;
  logic clamp_r;
  logic outv;
  logic issue;

  function automatic logic signed [BW-1:0] lanef(input logic [63:0] r, input logic [1:0] j);
    logic [15:0] v;
    v = r[16*j +: 16];
    return BW'($signed(v[COEF_BITS-1:0]));
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat(input logic signed [ACCW-1:0] v);
    if (v > ACCW'(SMAX)) return SMAX;
    if (v < ACCW'(SMIN)) return SMIN;
    return v[STATE_BITS-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= sspc_pkg::CAL_RESET;
      for (int i = 1; i < 8; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sspc_pkg::REG_CAL) cal <= cfg_data[55:0];
      else regs[cfg_index] <= cfg_data;
    end
  end

  // Operand selection for the current serial product.
  always_comb begin
    ma = '0;
    mb = '0;
    if (!ydone) begin
      if (term == 3'd0) begin
        ma = AW'($signed({1'b0, cal[11:0]}) - $signed({1'b0, ang}));
        mb = BW'({1'b0, cal[39:24]});
      end else begin
        ma = AW'($signed({1'b0, pos}) - $signed({1'b0, cal[23:12]}));
        mb = BW'({1'b0, cal[55:40]});
      end
    end else if (drv) begin
      ma = AW'(xn[term[1:0]]);
      mb = lanef(regs[sspc_pkg::REG_GAINS], term[1:0]);
    end else if (term < 3'd4) begin
      ma = AW'(xs[term[1:0]]);
      mb = lanef(regs[3'(row) + 3'd1], term[1:0]);
    end else begin
      ma = (term == 3'd4) ? AW'(y0) : AW'(y1);
      mb = lanef(row[1] ? regs[sspc_pkg::REG_BLOWER] : regs[sspc_pkg::REG_BUPPER],
                 {row[0], term[0]});
    end
  end

  sspc_mac #(.AW(AW), .BW(BW), .ACCW(ACCW)) u_mac (
    .clk(clk), .rst(rst), .ctrl(ctrl), .a(ma), .b(mb), .busy(mbusy), .acc(acc)
  );

  assign samples.ready = (state == S_IDLE);
  assign drive.valid = outv;
  assign drive.data = {dac_r, drv_r, clamp_r};

  // A product starts on every input transfer and from each row step.
  assign issue = (state == S_ROW) || (state == S_IDLE && samples.valid && samples.ready);

  logic signed [ACCW-1:0] rnd, u;
  always_comb begin
    rnd = (acc + ACCW'(2048)) >>> 12;
    u = ((-(acc <<< 2)) + ACCW'(32768)) >>> 16;
  end

  // Clamp the drive and scale it toward the DAC code:
  // (u + 40960) * 4095 / 81920 is ((u + 40960) * 4095 >> 14) / 5.
  logic signed [16:0] ucl_c;
  logic clamp_c;
  logic [17:0] uoff;
  logic [29:0] uscaled;
  logic signed [16:0] ucl;
  logic uclamp;
  logic [14:0] dn;
  logic [29:0] dmul;

  always_comb begin
    if (u > ACCW'(sspc_pkg::DRIVE_LIMIT)) begin
      ucl_c = 17'(sspc_pkg::DRIVE_LIMIT);
      clamp_c = 1'b1;
    end else if (u < -ACCW'(sspc_pkg::DRIVE_LIMIT)) begin
      ucl_c = -17'(sspc_pkg::DRIVE_LIMIT);
      clamp_c = 1'b1;
    end else begin
      ucl_c = u[16:0];
      clamp_c = 1'b0;
    end
    uoff = 18'(ucl_c) + 18'(sspc_pkg::DRIVE_LIMIT);
    uscaled = {uoff, 12'd0} - 30'(uoff);
  end

  assign dmul = 30'(dn) * DIV5_RECIP;

  // Sequencer: one product per serial pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctrl <= '0;
      outv <= 1'b0;
      term <= '0;
      row <= '0;
      ydone <= 1'b0;
      drv <= 1'b0;
      for (int i = 0; i < 4; i++) xs[i] <= '0;
    end else begin
      ctrl <= '{start: issue,
                clear: issue && ((state == S_IDLE) || !ydone || (term == 3'd0))};
      if (state == S_OUT && (!outv || drive.ready)) outv <= 1'b1;
      else if (outv && drive.ready) outv <= 1'b0;
      unique case (state)
        S_IDLE: if (samples.valid && samples.ready) begin
          ang <= samples.data[23:12] & SMASK;
          pos <= samples.data[11:0] & SMASK;
          term <= '0; row <= '0; ydone <= 1'b0; drv <= 1'b0;
          state <= S_WAIT;
        end
        S_ROW: begin
          state <= S_WAIT;
        end
        S_WAIT: if (!ctrl.start && !mbusy) begin
          if (!ydone) begin
            if (term == 3'd0) begin
              y0 <= sat(acc);
              term <= 3'd1;
              state <= S_ROW;
            end else begin
              y1 <= sat(acc - ACCW'(sspc_pkg::POS_OFFSET));
              ydone <= 1'b1;
              term <= '0;
              state <= S_ROW;
            end
          end else if (drv) begin
            if (term == 3'd3) state <= S_SCALE;
            else begin term <= term + 3'd1; state <= S_ROW; end
          end else if (term == 3'd5) state <= S_ROWEND;
          else begin term <= term + 3'd1; state <= S_ROW; end
        end
        S_ROWEND: begin
          xn[row[1:0]] <= sat(rnd);
          term <= '0;
          if (row == 3'd3) begin drv <= 1'b1; state <= S_DRV; end
          else begin row <= row + 3'd1; state <= S_ROW; end
        end
        S_DRV: begin
          for (int i = 0; i < 4; i++) xs[i] <= xn[i];
          state <= S_ROW;
        end
        S_SCALE: begin
          ucl <= ucl_c;
          uclamp <= clamp_c;
          dn <= uscaled[28:14];
          state <= S_OUT;
        end
        S_OUT: if (!outv || drive.ready) begin
          drv_r <= ucl;
          clamp_r <= uclamp;
          dac_r <= dmul[28:17];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    outv && !drive.ready |=> outv) else $error("result dropped");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !samples.ready) else $error("ready while busy");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    outv && !clamp_r |-> drv_r <= 17'sd40960 && drv_r >= -17'sd40960)
    else $error("drive out of range");
`endif
endmodule
